// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL. Each check samples on the rising edge of clk
// and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define JHG_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JHG_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`else

`define JHG_ASSERT_NOW(lbl, ant, con, msg)
`define JHG_ASSERT_NEXT(lbl, ant, con, msg)

`endif

`endif

// ----- hdl/jhg_pkg.sv -----
package jhg_pkg;

  // Command opcodes carried by the input word.
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GRID_SIDE = 2'd0;
  localparam logic [1:0] REG_WALL_TEMP = 2'd1;
  localparam logic [1:0] REG_FIRE_TEMP = 2'd2;
  localparam logic [1:0] REG_FIRE_RAD  = 2'd3;

  // Reset values of the registers.
  localparam logic [7:0]  GRID_SIDE_RST = 8'd128;
  localparam logic [15:0] WALL_TEMP_RST = 16'd0;
  localparam logic [15:0] FIRE_TEMP_RST = 16'd25600;
  localparam logic [7:0]  FIRE_RAD_RST  = 8'd16;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT_MUL,
    ST_INIT_WR,
    ST_STEP_UD,
    ST_STEP_LR,
    ST_STEP_WR,
    ST_READ,
    ST_READ_DATA,
    ST_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic setup;
    logic init_mul;
    logic init_wr;
    logic step_ud;
    logic step_lr;
    logic step_wr;
    logic rd_issue;
    logic rd_capture;
    logic finish;
  } jhg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cell;
    logic out_free;
  } jhg_sts_t;

endpackage

// ----- hdl/jhg_ctrl.sv -----
module jhg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  jhg_pkg::jhg_sts_t sts,
  output jhg_pkg::jhg_cmd_t cmd
);

  jhg_pkg::ctrl_state_t state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;

  // State and opcode registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jhg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;
  end

  // The opcode is held for the whole command.
  always_comb begin
    op_nxt = op_r;
    if (state_r == jhg_pkg::ST_IDLE && in_valid) begin
      op_nxt = in_opcode;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jhg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = jhg_pkg::ST_SETUP;
      end
      jhg_pkg::ST_SETUP: begin
        unique case (op_r)
          jhg_pkg::OP_INIT: state_nxt = jhg_pkg::ST_INIT_MUL;
          jhg_pkg::OP_STEP: state_nxt = jhg_pkg::ST_STEP_UD;
          jhg_pkg::OP_READ: state_nxt = jhg_pkg::ST_READ;
          default:          state_nxt = jhg_pkg::ST_DONE;
        endcase
      end
      jhg_pkg::ST_INIT_MUL:  state_nxt = jhg_pkg::ST_INIT_WR;
      jhg_pkg::ST_INIT_WR: begin
        state_nxt = sts.last_cell ? jhg_pkg::ST_DONE : jhg_pkg::ST_INIT_MUL;
      end
      jhg_pkg::ST_STEP_UD:   state_nxt = jhg_pkg::ST_STEP_LR;
      jhg_pkg::ST_STEP_LR:   state_nxt = jhg_pkg::ST_STEP_WR;
      jhg_pkg::ST_STEP_WR: begin
        state_nxt = sts.last_cell ? jhg_pkg::ST_DONE : jhg_pkg::ST_STEP_UD;
      end
      jhg_pkg::ST_READ:      state_nxt = jhg_pkg::ST_READ_DATA;
      jhg_pkg::ST_READ_DATA: state_nxt = jhg_pkg::ST_DONE;
      jhg_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = jhg_pkg::ST_IDLE;
      end
      default: state_nxt = jhg_pkg::ST_IDLE;
    endcase
  end

  // Commands decoded from the state.
  always_comb begin
    cmd            = '0;
    in_ready       = (state_r == jhg_pkg::ST_IDLE);
    cmd.accept     = (state_r == jhg_pkg::ST_IDLE) && in_valid;
    cmd.setup      = (state_r == jhg_pkg::ST_SETUP);
    cmd.init_mul   = (state_r == jhg_pkg::ST_INIT_MUL);
    cmd.init_wr    = (state_r == jhg_pkg::ST_INIT_WR);
    cmd.step_ud    = (state_r == jhg_pkg::ST_STEP_UD);
    cmd.step_lr    = (state_r == jhg_pkg::ST_STEP_LR);
    cmd.step_wr    = (state_r == jhg_pkg::ST_STEP_WR);
    cmd.rd_issue   = (state_r == jhg_pkg::ST_READ);
    cmd.rd_capture = (state_r == jhg_pkg::ST_READ_DATA);
    cmd.finish     = (state_r == jhg_pkg::ST_DONE) && sts.out_free;
  end

endmodule

// ----- hdl/jhg_dp.sv -----
module jhg_dp #(
  parameter int MAX_SIDE   = 128,
  parameter int TEMP_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jhg_pkg::jhg_cmd_t cmd,
  output jhg_pkg::jhg_sts_t sts,
  input  logic [13:0]       in_cell_index,
  input  logic [7:0]        grid_side,
  input  logic [15:0]       wall_heat,
  input  logic [15:0]       fire_heat,
  input  logic [7:0]        fire_radius,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_temperature,
  output logic              out_is_fire,
  output logic [31:0]       out_iterations_done
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int TW    = TEMP_WIDTH;
  localparam int PW    = 2 * SW + 2;
  localparam int CW    = (2 * SW + 7 > 22) ? 2 * SW + 7 : 22;

  // Temperature buffers and fire mask.
  logic [TW-1:0] mem_a [DEPTH];
  logic [TW-1:0] mem_b [DEPTH];
  logic          mask_mem [DEPTH];
  logic [TW-1:0] a_q0_r, a_q1_r, b_q0_r, b_q1_r;
  logic          mask_q_r;

  // Geometry held for the current command.
  logic [SW-1:0]   s_r, h_r, t_r;
  logic [2*SW-1:0] s_sq_r;
  logic [19:0]     tenf_r;
  logic [13:0]     hsq_r;
  logic [13:0]     idx_r;

  // Cell walk and state.
  logic [SW-1:0] row_r, col_r;
  logic [AW-1:0] k_r;
  logic          cur_r;
  logic [31:0]   iter_r;
  logic [TW:0]   sum_r;
  logic signed [PW-1:0] pa_r, pb_r, pab_r, pc_r, pd_r;
  logic [TW-1:0] rd_temp_r;
  logic          rd_fire_r;

  logic          out_valid_r;
  logic [15:0]   out_temp_r;
  logic          out_fire_r;
  logic [31:0]   out_iter_r;

  // Combinational helpers.
  logic [15:0]     side_ext, side_clamp;
  logic [SW+10:0]  third_mul;
  logic [15:0]     f_sq;
  logic [6:0]      f_half;
  logic signed [SW:0] ea, eb, ec, ed;
  logic signed [CW-1:0] ell_lhs, circ_lhs, tenf_s, hsq_s;
  logic          fire_bit;
  logic [AW-1:0] s_aw, ra0, ra1, ma;
  logic [TW-1:0] src0, src1, wall_w, fire_w, avg, step_val;
  logic [TW+1:0] total;
  logic          is_edge, in_range, last_cell, advance;

  // Grid side saturated into the supported range.
  always_comb begin
    side_ext = 16'(grid_side);
    if (side_ext < 16'd3) begin
      side_clamp = 16'd3;
    end else if (side_ext > 16'(MAX_SIDE)) begin
      side_clamp = 16'(MAX_SIDE);
    end else begin
      side_clamp = side_ext;
    end
  end

  // Side over three by reciprocal multiply, exact for sides below 2048.
  assign third_mul = (SW+11)'(s_r) * (SW+11)'(683);
  assign f_sq      = 16'(fire_radius) * 16'(fire_radius);
  assign f_half    = 7'(fire_radius >> 1);

  // Offsets of the current cell from the two fire centres.
  assign ea = $signed({1'b0, row_r}) - $signed({1'b0, h_r});
  assign eb = $signed({1'b0, col_r}) - $signed({1'b0, h_r});
  assign ec = $signed({1'b0, row_r}) - $signed({1'b0, t_r});
  assign ed = $signed({1'b0, col_r}) - $signed({1'b0, t_r});

  // Ellipse and circle tests on the registered products.
  always_comb begin
    ell_lhs  = (CW'(pa_r) <<< 2) + CW'(pa_r) + (CW'(pb_r) <<< 3)
             - ((CW'(pab_r) <<< 2) + CW'(pab_r));
    circ_lhs = CW'(pc_r) + CW'(pd_r);
    tenf_s   = CW'(tenf_r);
    hsq_s    = CW'(hsq_r);
    fire_bit = (ell_lhs < tenf_s) || (circ_lhs < hsq_s);
  end

  // Neighbour addresses: up and down first, then left and right.
  always_comb begin
    s_aw = AW'(s_r);
    ra0  = AW'(idx_r);
    ra1  = k_r;
    if (cmd.step_ud) begin
      ra0 = k_r - s_aw;
      ra1 = k_r + s_aw;
    end else if (cmd.step_lr) begin
      ra0 = k_r - AW'(1);
      ra1 = k_r + AW'(1);
    end
    ma = cmd.rd_issue ? AW'(idx_r) : k_r;
  end

  // New cell value for a step.
  always_comb begin
    src0     = cur_r ? b_q0_r : a_q0_r;
    src1     = cur_r ? b_q1_r : a_q1_r;
    wall_w   = TW'(wall_heat);
    fire_w   = TW'(fire_heat);
    total    = (TW+2)'(sum_r) + (TW+2)'(src0) + (TW+2)'(src1);
    avg      = TW'(total >> 2);
    is_edge  = (row_r == '0) || (col_r == '0) ||
               (row_r == s_r - SW'(1)) || (col_r == s_r - SW'(1));
    step_val = is_edge ? wall_w : (mask_q_r ? fire_w : avg);
    in_range = 32'(idx_r) < 32'(s_sq_r);
    last_cell = (row_r == s_r - SW'(1)) && (col_r == s_r - SW'(1));
    advance   = cmd.init_wr || cmd.step_wr;
  end

  // Memory ports: one write and two reads per buffer, registered read data.
  always_ff @(posedge clk) begin
    if (cmd.init_wr || (cmd.step_wr && cur_r)) begin
      mem_a[k_r] <= cmd.init_wr ? wall_w : step_val;
    end
    if (cmd.init_wr || (cmd.step_wr && !cur_r)) begin
      mem_b[k_r] <= cmd.init_wr ? wall_w : step_val;
    end
    if (cmd.init_wr) begin
      mask_mem[k_r] <= fire_bit;
    end
    a_q0_r   <= mem_a[ra0];
    a_q1_r   <= mem_a[ra1];
    b_q0_r   <= mem_b[ra0];
    b_q1_r   <= mem_b[ra1];
    mask_q_r <= mask_mem[ma];
  end

  // Per-command geometry and datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r   <= SW'(side_clamp);
      idx_r <= in_cell_index;
    end
    if (cmd.setup) begin
      s_sq_r    <= (2*SW)'(s_r) * (2*SW)'(s_r);
      h_r       <= s_r >> 1;
      t_r       <= SW'(third_mul >> 11);
      tenf_r    <= (20'(f_sq) << 3) + (20'(f_sq) << 1);
      hsq_r     <= 14'(f_half) * 14'(f_half);
      row_r     <= '0;
      col_r     <= '0;
      k_r       <= '0;
      rd_temp_r <= '0;
      rd_fire_r <= 1'b0;
    end
    if (cmd.init_mul) begin
      pa_r  <= PW'(ea) * PW'(ea);
      pb_r  <= PW'(eb) * PW'(eb);
      pab_r <= PW'(ea) * PW'(eb);
      pc_r  <= PW'(ec) * PW'(ec);
      pd_r  <= PW'(ed) * PW'(ed);
    end
    if (cmd.step_lr) begin
      sum_r <= {1'b0, src0} + {1'b0, src1};
    end
    if (advance) begin
      k_r <= k_r + AW'(1);
      if (col_r == s_r - SW'(1)) begin
        col_r <= '0;
        row_r <= row_r + SW'(1);
      end else begin
        col_r <= col_r + SW'(1);
      end
    end
    if (cmd.rd_capture) begin
      rd_temp_r <= in_range ? src0 : '0;
      rd_fire_r <= in_range && mask_q_r;
    end
  end

  // Buffer select and iteration count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= 1'b0;
      iter_r <= '0;
    end else if (cmd.init_wr && last_cell) begin
      cur_r  <= 1'b0;
      iter_r <= '0;
    end else if (cmd.step_wr && last_cell) begin
      cur_r <= ~cur_r;
      if (iter_r != '1) iter_r <= iter_r + 32'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_temp_r <= 16'(rd_temp_r);
      out_fire_r <= rd_fire_r;
      out_iter_r <= iter_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature     = out_temp_r;
  assign out_is_fire         = out_fire_r;
  assign out_iterations_done = out_iter_r;
  assign sts.last_cell       = last_cell;
  assign sts.out_free        = !out_valid_r || out_ready;

endmodule

// ----- hdl/jacobi_heat_grid_stencil.sv -----
// Jacobi heat grid: a square grid of up to MAX_SIDE by MAX_SIDE Q8.8 cells in two
// on-chip buffers plus a fire mask. Each input word is one command and gives one
// result word. Init takes one shared product stage and one write per cell. A step is set
// by the two read ports of each buffer: the four neighbours of a cell are fetched two
// per cycle, then the cell is written. A read issues the address, then captures the
// data. A new command is taken once the previous result sits in the output register.
// Registers sit at byte addresses 0, 4, 8 and 12 of the configuration port.
`include "assert_macros.svh"

module jacobi_heat_grid_stencil #(
  parameter int MAX_SIDE   = 128,
  parameter int TEMP_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_temperature,
  output logic        out_is_fire,
  output logic [31:0] out_iterations_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        side_r;
  logic [15:0]       wall_r;
  logic [15:0]       fire_r;
  logic [7:0]        radius_r;
  logic              wr_en;
  jhg_pkg::jhg_cmd_t cmd;
  jhg_pkg::jhg_sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= jhg_pkg::GRID_SIDE_RST;
      wall_r   <= jhg_pkg::WALL_TEMP_RST;
      fire_r   <= jhg_pkg::FIRE_TEMP_RST;
      radius_r <= jhg_pkg::FIRE_RAD_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        jhg_pkg::REG_GRID_SIDE: side_r   <= pwdata[7:0];
        jhg_pkg::REG_WALL_TEMP: wall_r   <= pwdata[15:0];
        jhg_pkg::REG_FIRE_TEMP: fire_r   <= pwdata[15:0];
        jhg_pkg::REG_FIRE_RAD:  radius_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      jhg_pkg::REG_GRID_SIDE: prdata = 32'(side_r);
      jhg_pkg::REG_WALL_TEMP: prdata = 32'(wall_r);
      jhg_pkg::REG_FIRE_TEMP: prdata = 32'(fire_r);
      jhg_pkg::REG_FIRE_RAD:  prdata = 32'(radius_r);
      default:                prdata = '0;
    endcase
  end

  // Command sequencer.
  jhg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Grid memories and arithmetic.
  jhg_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_cell_index       (in_cell_index),
    .grid_side           (side_r),
    .wall_heat           (wall_r),
    .fire_heat           (fire_r),
    .fire_radius         (radius_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_temperature     (out_temperature),
    .out_is_fire         (out_is_fire),
    .out_iterations_done (out_iterations_done)
  );

  // The block is busy in the cycle after it takes a word.
  `JHG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "not busy after accept")
  // A fresh result only leaves a busy block.
  `JHG_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result while idle")

endmodule

// ----- test/tb_jacobi_heat_grid_stencil.sv -----
`timescale 1ns / 100ps

module tb_jacobi_heat_grid_stencil;

  // Opcode that the block leaves unused; it must answer as a non-read command.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int CELL_MAX = 16384;
  localparam int STALL_LIMIT = 200000;

  // Heat grid predictor with the store of expected result words.
  class heat_board;
    logic [15:0] grid [2][CELL_MAX];
    bit          mask [CELL_MAX];
    bit          cur;
    logic [31:0] iters;
    logic [7:0]  side_reg;
    logic [15:0] wall_reg;
    logic [15:0] fire_reg;
    logic [7:0]  rad_reg;
    logic [15:0] exp_temp [$];
    bit          exp_fire [$];
    logic [31:0] exp_iter [$];

    function new();
      cur = 0;
      iters = '0;
      side_reg = jhg_pkg::GRID_SIDE_RST;
      wall_reg = jhg_pkg::WALL_TEMP_RST;
      fire_reg = jhg_pkg::FIRE_TEMP_RST;
      rad_reg = jhg_pkg::FIRE_RAD_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        jhg_pkg::REG_GRID_SIDE: side_reg = v[7:0];
        jhg_pkg::REG_WALL_TEMP: wall_reg = v[15:0];
        jhg_pkg::REG_FIRE_TEMP: fire_reg = v[15:0];
        jhg_pkg::REG_FIRE_RAD:  rad_reg = v[7:0];
        default: ;
      endcase
    endfunction

    function int side_now();
      int s;
      s = side_reg;
      if (s < 3) s = 3;
      if (s > 128) s = 128;
      return s;
    endfunction

    // Ellipse at the centre or circle at one third of the side.
    function bit burning(longint i, longint j, longint s);
      longint f;
      longint a;
      longint b;
      f = rad_reg;
      a = i - s / 2;
      b = j - s / 2;
      if (5 * a * a + 8 * b * b - 5 * a * b < 10 * f * f) return 1;
      a = i - s / 3;
      b = j - s / 3;
      return (a * a + b * b < (f / 2) * (f / 2));
    endfunction

    function int pending();
      return exp_temp.size();
    endfunction

    // Apply an accepted command and queue the word it should produce.
    function void note_input(logic [1:0] op, logic [13:0] idx);
      int s;
      int k;
      bit nxt;
      logic [17:0] sum;
      logic [15:0] t;
      bit fb;
      s = side_now();
      t = '0;
      fb = 0;
      nxt = !cur;
      case (op)
        jhg_pkg::OP_INIT: begin
          for (int r = 0; r < s; r++) begin
            for (int c = 0; c < s; c++) begin
              k = r * s + c;
              grid[0][k] = wall_reg;
              grid[1][k] = wall_reg;
              mask[k] = burning(r, c, s);
            end
          end
          cur = 0;
          iters = '0;
        end
        jhg_pkg::OP_STEP: begin
          for (int r = 0; r < s; r++) begin
            for (int c = 0; c < s; c++) begin
              k = r * s + c;
              if (r == 0 || c == 0 || r == s - 1 || c == s - 1) begin
                grid[nxt][k] = wall_reg;
              end else if (mask[k]) begin
                grid[nxt][k] = fire_reg;
              end else begin
                sum = 18'(grid[cur][k - s]) + 18'(grid[cur][k + s]) +
                      18'(grid[cur][k - 1]) + 18'(grid[cur][k + 1]);
                grid[nxt][k] = sum[17:2];
              end
            end
          end
          cur = nxt;
          if (iters != 32'hFFFF_FFFF) iters = iters + 1;
        end
        jhg_pkg::OP_READ: begin
          if (int'(idx) < s * s) begin
            t = grid[cur][idx];
            fb = mask[idx];
          end
        end
        default: ;
      endcase
      exp_temp.push_back(t);
      exp_fire.push_back(fb);
      exp_iter.push_back(iters);
    endfunction

    // Compare a result word with the oldest expectation; empty string when it matches.
    function string check(logic [15:0] t, logic fb, logic [31:0] it);
      string msg;
      logic [15:0] et;
      bit ef;
      logic [31:0] ei;
      msg = "";
      if (exp_temp.size() == 0) return "result word with nothing expected";
      et = exp_temp.pop_front();
      ef = exp_fire.pop_front();
      ei = exp_iter.pop_front();
      if (t !== et) msg = {msg, $sformatf(" temperature %h/%h", t, et)};
      if (fb !== ef) msg = {msg, $sformatf(" is_fire %b/%b", fb, ef)};
      if (it !== ei) msg = {msg, $sformatf(" iterations %0d/%0d", it, ei)};
      if (msg != "") msg = {"mismatch (got/exp):", msg};
      return msg;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [13:0] in_cell_index = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] out_temperature;
  logic        out_is_fire;
  logic [31:0] out_iterations_done;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  heat_board board = new();
  int errors = 0;
  int idle_cycles = 0;
  int written_cells = 0;
  bit quiet = 0;
  int out_hold = 0;

  jacobi_heat_grid_stencil uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_cell_index(in_cell_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temperature(out_temperature), .out_is_fire(out_is_fire),
    .out_iterations_done(out_iterations_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  task automatic report(string msg);
    errors++;
    $display("%0t: %s", $realtime, msg);
  endtask

  // Mostly short gaps, a few long ones, none at all in quiet phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure and the check of each word taken.
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      msg = board.check(out_temperature, out_is_fire, out_iterations_done);
      if (msg != "") report(msg);
    end
    if (out_hold > 0) begin
      out_ready <= 0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= rst_n;
      if ($urandom_range(0, 3) == 0) out_hold <= pick_gap();
    end
  end

  // Watchdog on cycles with no word moving on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_jacobi_heat_grid_stencil: done, errors");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, logic [13:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, idx);
    if (op == jhg_pkg::OP_INIT && board.side_now() ** 2 > written_cells)
      written_cells = board.side_now() ** 2;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_reg(idx, v);
  endtask

  // Wait until every expected word has come back, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_all(int side, int wall, int fire, int rad);
    cfg_write(jhg_pkg::REG_GRID_SIDE, side);
    cfg_write(jhg_pkg::REG_WALL_TEMP, wall);
    cfg_write(jhg_pkg::REG_FIRE_TEMP, fire);
    cfg_write(jhg_pkg::REG_FIRE_RAD, rad);
  endtask

  // Random commands on one setting; init first when the grid is not covered yet.
  task automatic random_phase(int n, bit big);
    int s;
    int r;
    bit stepped;
    s = board.side_now();
    stepped = 0;
    if (s * s > written_cells) send(jhg_pkg::OP_INIT, 14'($urandom()));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8 && !big) begin
        send(jhg_pkg::OP_INIT, 14'($urandom()));
      end else if (r < 40 && !(big && stepped)) begin
        send(jhg_pkg::OP_STEP, 14'($urandom()));
        stepped = 1;
      end else if (r < 93) begin
        if ($urandom_range(0, 4) == 0) send(jhg_pkg::OP_READ, 14'($urandom()));
        else send(jhg_pkg::OP_READ, 14'($urandom_range(0, s * s - 1)));
      end else begin
        send(OP_NOP, 14'($urandom()));
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();
  endtask

  function automatic int pick_temp();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    int side;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset setting: full grid, fire cells read as wall until the first step.
    send(jhg_pkg::OP_INIT, 14'd0);
    send(jhg_pkg::OP_READ, 14'd0);
    send(jhg_pkg::OP_READ, 14'd16383);
    send(jhg_pkg::OP_READ, 14'(64 * 128 + 64));
    send(OP_NOP, 14'd5);
    send(jhg_pkg::OP_STEP, 14'd0);
    send(jhg_pkg::OP_READ, 14'(64 * 128 + 64));
    send(jhg_pkg::OP_READ, 14'd129);
    send(jhg_pkg::OP_STEP, 14'd0);
    send(jhg_pkg::OP_READ, 14'd130);
    send(jhg_pkg::OP_READ, 14'd127);
    drain();

    // Side above range saturates; side changed without a fresh init.
    set_all(255, 65535, 0, 128);
    send(jhg_pkg::OP_READ, 14'(64 * 128 + 64));
    send(jhg_pkg::OP_STEP, 14'd0);
    send(jhg_pkg::OP_READ, 14'd129);
    send(jhg_pkg::OP_READ, 14'd16383);
    drain();

    // Side below range saturates to three; everything inside is fire.
    set_all(0, 65535, 65535, 128);
    send(jhg_pkg::OP_INIT, 14'd0);
    send(jhg_pkg::OP_STEP, 14'd0);
    send(jhg_pkg::OP_READ, 14'd4);
    send(jhg_pkg::OP_READ, 14'd9);
    send(jhg_pkg::OP_READ, 14'd16383);
    drain();

    // No fire, hot walls averaged inwards.
    set_all(5, 65535, 65535, 0);
    send(jhg_pkg::OP_INIT, 14'd0);
    send(jhg_pkg::OP_STEP, 14'd0);
    send(jhg_pkg::OP_STEP, 14'd0);
    send(jhg_pkg::OP_READ, 14'd12);
    send(jhg_pkg::OP_READ, 14'd6);
    drain();

    // Random settings, mostly small grids, one large one.
    for (int ph = 0; ph < 9; ph++) begin
      quiet = (ph % 3 == 0);
      if (ph == 4) side = 40;
      else if ($urandom_range(0, 7) == 0) side = $urandom_range(0, 2);
      else side = $urandom_range(3, 14);
      set_all(side, pick_temp(), pick_temp(),
              ($urandom_range(0, 7) == 0) ? 128 : $urandom_range(0, 9));
      random_phase(8, ph == 4);
    end
    quiet = 0;
    drain();

    if (errors == 0) begin
      $display("tb_jacobi_heat_grid_stencil: done, clean");
    end else begin
      $display("tb_jacobi_heat_grid_stencil: done, errors");
    end
    $finish;
  end

endmodule
